FILE: rtl/btlv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package btlv_pkg;
  localparam int unsigned MAX_LEN_BYTES_DEF = 4;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_SCALAR  = 3'd1;
  localparam logic [2:0] KIND_CONTENT = 3'd2;
  localparam logic [2:0] KIND_ARC     = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TAG       = 2'd1;
  localparam logic [1:0] ERR_LEN       = 2'd2;
  localparam logic [1:0] ERR_TRUNC     = 2'd3;

  localparam logic [7:0] TAG_INT  = 8'h02;
  localparam logic [7:0] TAG_OCT  = 8'h04;
  localparam logic [7:0] TAG_NULL = 8'h05;
  localparam logic [7:0] TAG_OID  = 8'h06;
  localparam logic [7:0] TAG_APP2 = 8'h42;
  localparam logic [7:0] TAG_APP3 = 8'h43;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } btlv_in_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [7:0]  element_tag;
    logic [31:0] element_length;
    logic [31:0] item_value;
    logic [1:0]  error_code;
    logic        run_last;
  } btlv_out_t;

  // One byte's worth of results, up to three.
  typedef struct packed {
    logic [1:0]   count;
    btlv_out_t [2:0] rec;
  } btlv_group_t;

  function automatic logic is_scalar(input logic [7:0] t);
    return t == TAG_INT || t == TAG_APP2 || t == TAG_APP3;
  endfunction

  function automatic logic is_known(input logic [7:0] t);
    return is_scalar(t) || t == TAG_OCT || t == TAG_NULL || t == TAG_OID;
  endfunction

  function automatic btlv_out_t mk(input logic [2:0] k, input logic [7:0] t,
                                   input logic [31:0] l, input logic [31:0] v,
                                   input logic [1:0] e);
    btlv_out_t r;
    r.record_kind = k;
    r.element_tag = t;
    r.element_length = l;
    r.item_value = v;
    r.error_code = e;
    r.run_last = 1'b0;
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/ber_tlv_element_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_item (data_byte, buffer_end)
// out     | output    | out_valid, out_stall, out_item (six result fields)
// One byte is parsed per cycle, unless in_stall holds it, in the front state update; a byte makes 0..3 results.
// Results leave one per cycle, unless out_stall holds them, from a two-group queue, so the input rate is one byte per
// cycle while bytes make at most one result each, else bounded by the output port.
// Synchronous active-low reset returns the parser to expecting a tag and empties the queue.
// in_stall rises when the queue is full; out_stall only holds the current result.
module ber_tlv_element_decoder #(
  parameter int unsigned MAX_LEN_BYTES = btlv_pkg::MAX_LEN_BYTES_DEF,
  parameter int unsigned VALUE_BITS = btlv_pkg::VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire btlv_pkg::btlv_in_t in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output btlv_pkg::btlv_out_t     out_item
);
  import btlv_pkg::*;

  btlv_group_t f_grp, q_grp;
  logic full, step, q_valid, q_pop;

  assign in_stall = full;
  assign step = in_valid && !full;

  btlv_front #(.MAX_LEN_BYTES(MAX_LEN_BYTES), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst_n, .step, .in_item, .grp(f_grp));

  btlv_queue u_queue (
    .clk, .rst_n, .wr_en(step && f_grp.count != 2'd0), .wr_grp(f_grp), .full,
    .rd_valid(q_valid), .rd_grp(q_grp), .rd_en(q_pop));

  btlv_back u_back (
    .clk, .rst_n, .q_valid, .q_grp, .q_pop, .out_valid, .out_item, .out_stall);
endmodule
`default_nettype wire

FILE: rtl/btlv_front.sv
`timescale 1ns / 1ps
`default_nettype none
module btlv_front #(
  parameter int unsigned MAX_LEN_BYTES = 4,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire btlv_pkg::btlv_in_t  in_item,
  output btlv_pkg::btlv_group_t    grp
);
  import btlv_pkg::*;

  typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_LENX, PH_BODY} phase_t;

  phase_t phase_r, phase_nxt;
  logic [7:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [2:0] left_r, left_nxt;
  logic [31:0] cont_r, cont_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic first_r, first_nxt;
  logic drain_r, drain_nxt;

  logic [7:0] b;
  logic       fin;
  logic [6:0] k;
  logic [7:0] q40, r40;
  logic [63:0] vwide;
  btlv_out_t [2:0] rec;
  logic [1:0] n;

  assign b = in_item.data_byte;
  assign fin = in_item.buffer_end;
  assign k = b[6:0];
  // b/40 via reciprocal: floor(b*205/8192) is exact for b < 256
  assign q40 = 8'(({8'd0, b} * 16'd205) >> 13);
  assign r40 = b - 8'(q40 * 8'd40);
  assign vwide = 64'(val_r);

  always_comb begin
    logic hdr;
    logic [31:0] hlen;
    logic [VALUE_BITS-1:0] nv;
    phase_nxt = phase_r; tag_nxt = tag_r; len_nxt = len_r; left_nxt = left_r;
    cont_nxt = cont_r; val_nxt = val_r; first_nxt = first_r; drain_nxt = drain_r;
    rec = '0; n = 2'd0; hdr = 1'b0; hlen = 32'd0; nv = '0;
    if (drain_r) begin
      if (fin) begin
        drain_nxt = 1'b0; phase_nxt = PH_TAG;
      end
    end else begin
      unique case (phase_r)
        PH_LEN: begin
          if (b[7]) begin
            if (32'(k) > 32'(MAX_LEN_BYTES)) begin
              rec[n] = mk(KIND_ERROR, tag_r, 32'd0, 32'd0, ERR_LEN); n = n + 2'd1;
              phase_nxt = PH_TAG; drain_nxt = !fin;
            end else if (k == 7'd0) begin
              len_nxt = 32'd0; hdr = 1'b1; hlen = 32'd0;
            end else begin
              len_nxt = 32'd0; left_nxt = k[2:0]; phase_nxt = PH_LENX;
            end
          end else begin
            len_nxt = {24'd0, b}; hdr = 1'b1; hlen = {24'd0, b};
          end
        end
        PH_LENX: begin
          len_nxt = {len_r[23:0], b};
          left_nxt = left_r - 3'd1;
          if (left_r == 3'd1) begin
            hdr = 1'b1; hlen = {len_r[23:0], b};
          end
        end
        PH_BODY: begin
          if (is_scalar(tag_r)) begin
            nv = VALUE_BITS'({vwide[55:0], b});
            val_nxt = nv;
          end else if (tag_r == TAG_OID) begin
            if (first_r) begin
              rec[0] = mk(KIND_ARC, tag_r, len_r, {24'd0, q40}, ERR_NONE);
              rec[1] = mk(KIND_ARC, tag_r, len_r, {24'd0, r40}, ERR_NONE);
              n = 2'd2;
            end else begin
              rec[0] = mk(KIND_ARC, tag_r, len_r, {24'd0, b}, ERR_NONE); n = 2'd1;
            end
          end else begin
            rec[0] = mk(KIND_CONTENT, tag_r, len_r, {24'd0, b}, ERR_NONE); n = 2'd1;
          end
          first_nxt = 1'b0;
          cont_nxt = cont_r - 32'd1;
          if (cont_r == 32'd1) begin
            if (is_scalar(tag_r)) begin
              rec[n] = mk(KIND_SCALAR, tag_r, len_r, 32'(64'(nv)), ERR_NONE);
              n = n + 2'd1;
            end
            phase_nxt = PH_TAG;
          end
        end
        default: begin
          if (fin) begin
            rec[0] = mk(KIND_ERROR, b, 32'd0, 32'd0, ERR_TRUNC); n = 2'd1;
            phase_nxt = PH_TAG;
          end else if (!is_known(b)) begin
            rec[0] = mk(KIND_ERROR, b, 32'd0, 32'd0, ERR_TAG); n = 2'd1;
            phase_nxt = PH_TAG; drain_nxt = 1'b1;
          end else begin
            tag_nxt = b; len_nxt = 32'd0; left_nxt = 3'd0; phase_nxt = PH_LEN;
          end
        end
      endcase
      if (hdr) begin
        rec[n] = mk(KIND_HEADER, tag_r, hlen, 32'd0, ERR_NONE); n = n + 2'd1;
        cont_nxt = hlen; val_nxt = '0; first_nxt = 1'b1;
        if (hlen == 32'd0) begin
          if (is_scalar(tag_r)) begin
            rec[n] = mk(KIND_SCALAR, tag_r, 32'd0, 32'd0, ERR_NONE); n = n + 2'd1;
          end
          phase_nxt = PH_TAG;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      if (fin && phase_nxt != PH_TAG) begin
        rec[n] = mk(KIND_ERROR, tag_r, 32'd0, 32'd0, ERR_TRUNC); n = n + 2'd1;
        phase_nxt = PH_TAG;
      end
      if (fin) drain_nxt = 1'b0;
    end
    if (n != 2'd0) rec[n - 2'd1].run_last = 1'b1;
  end

  assign grp.count = n;
  assign grp.rec = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG; tag_r <= '0; len_r <= '0; left_r <= '0;
      cont_r <= '0; val_r <= '0; first_r <= 1'b1; drain_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; tag_r <= tag_nxt; len_r <= len_nxt; left_r <= left_nxt;
      cont_r <= cont_nxt; val_r <= val_nxt; first_r <= first_nxt; drain_r <= drain_nxt;
    end
  end

  ap_drain_silent: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> grp.count == 2'd0) else $error("output while draining");
  ap_end_to_tag: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_item.buffer_end |=> phase_r == PH_TAG && !drain_r)
    else $error("buffer end did not return to tag");
  ap_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LENX |-> left_r != 3'd0 && 32'(left_r) <= 32'(MAX_LEN_BYTES))
    else $error("length byte count out of range");
endmodule
`default_nettype wire

FILE: rtl/btlv_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module btlv_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire btlv_pkg::btlv_group_t wr_grp,
  output logic                       full,
  output logic                       rd_valid,
  output btlv_pkg::btlv_group_t      rd_grp,
  input  wire logic                  rd_en
);
  import btlv_pkg::*;
  // two-entry queue of result groups
  btlv_group_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_grp = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en) else $error("queue overflow");
  ap_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> rd_valid) else $error("queue underflow");
endmodule
`default_nettype wire

FILE: rtl/btlv_back.sv
`timescale 1ns / 1ps
`default_nettype none
module btlv_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire btlv_pkg::btlv_group_t q_grp,
  output logic                       q_pop,
  output logic                       out_valid,
  output btlv_pkg::btlv_out_t        out_item,
  input  wire logic                  out_stall
);
  import btlv_pkg::*;
  logic [1:0] idx_r;
  logic last;

  assign out_valid = q_valid;
  assign out_item = q_grp.rec[idx_r];
  assign last = idx_r == q_grp.count - 2'd1;
  assign q_pop = q_valid && !out_stall && last;

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else if (q_valid && !out_stall) idx_r <= last ? 2'd0 : idx_r + 2'd1;
  end

  ap_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> idx_r < q_grp.count) else $error("record index past group");
  ap_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> out_item.run_last) else $error("group ends without run_last");
endmodule
`default_nettype wire

FILE: tb/sv/ber_tlv_element_decoder_tb.sv
`timescale 1ns / 1ps
module ber_tlv_element_decoder_tb;
  import btlv_pkg::*;

  localparam int LEN_BYTES_MAX = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int STREAM_MAX = 512;
  localparam int DUE_MAX = 4096;

  typedef enum logic [2:0] {
    PH_TAG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_LENX = 3'd2,
    PH_BODY = 3'd3
  } phase_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  btlv_in_t in_item;
  logic out_valid;
  logic out_stall;
  btlv_out_t out_item;

  ber_tlv_element_decoder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // parser state mirror
  phase_t      ph;
  logic [7:0]  tag_q;
  logic [31:0] len_q;
  logic [2:0]  len_left;
  logic [31:0] body_left;
  logic [31:0] val_q;
  logic        first_q;
  logic        drain_q;

  btlv_out_t due_mem[DUE_MAX];
  int        due_wr;
  int        due_rd;
  btlv_out_t step_recs[3];
  int        step_n;
  btlv_in_t  stream_mem[STREAM_MAX];
  int        stream_len;
  int        stream_rd;
  btlv_out_t pinned_rec[STREAM_MAX];   // typed-in expectation for directed rows
  bit        pinned_use[STREAM_MAX];
  int        errors;
  int        mismatches;
  int        n_bytes;
  int        n_records;
  int        cycle_cnt;
  bit        hold_long;
  bit        stim_done;

  function automatic bit scalar_tag(input logic [7:0] t);
    return t == TAG_INT || t == TAG_APP2 || t == TAG_APP3;
  endfunction

  function automatic bit known_tag(input logic [7:0] t);
    return scalar_tag(t) || t == TAG_OCT || t == TAG_NULL || t == TAG_OID;
  endfunction

  function automatic btlv_out_t rec(input logic [2:0] k, input logic [7:0] t,
                                    input logic [31:0] l, input logic [31:0] v,
                                    input logic [1:0] e);
    btlv_out_t r;
    r.record_kind = k;
    r.element_tag = t;
    r.element_length = l;
    r.item_value = v;
    r.error_code = e;
    r.run_last = 1'b0;
    return r;
  endfunction

  task automatic add_step_rec(input btlv_out_t r);
    step_recs[step_n] = r;
    step_n = step_n + 1;
  endtask

  task automatic raise_error(input logic [7:0] t, input logic [1:0] code, input bit last_byte);
    add_step_rec(rec(KIND_ERROR, t, 32'd0, 32'd0, code));
    ph = PH_TAG;
    drain_q = !last_byte;
  endtask

  task automatic close_header();
    add_step_rec(rec(KIND_HEADER, tag_q, len_q, 32'd0, ERR_NONE));
    body_left = len_q;
    val_q = '0;
    first_q = 1'b1;
    if (len_q == 0) begin
      if (scalar_tag(tag_q)) add_step_rec(rec(KIND_SCALAR, tag_q, 32'd0, 32'd0, ERR_NONE));
      ph = PH_TAG;
    end else begin
      ph = PH_BODY;
    end
  endtask

  task automatic decode_byte(input btlv_in_t it);
    logic [7:0] b;
    bit last_byte;
    int k;
    b = it.data_byte;
    last_byte = it.buffer_end;
    step_n = 0;
    if (drain_q) begin
      if (last_byte) begin
        drain_q = 1'b0;
        ph = PH_TAG;
      end
      return;
    end
    case (ph)
      PH_LEN: begin
        if (b[7]) begin
          k = b[6:0];
          if (k > LEN_BYTES_MAX) raise_error(tag_q, ERR_LEN, last_byte);
          else if (k == 0) begin
            len_q = '0;
            close_header();
          end else begin
            len_q = '0;
            len_left = k[2:0];
            ph = PH_LENX;
          end
        end else begin
          len_q = {24'd0, b};
          close_header();
        end
      end
      PH_LENX: begin
        len_q = {len_q[23:0], b};
        len_left = len_left - 3'd1;
        if (len_left == 0) close_header();
      end
      PH_BODY: begin
        if (scalar_tag(tag_q)) val_q = {val_q[23:0], b};
        else if (tag_q == TAG_OID) begin
          if (first_q) begin
            add_step_rec(rec(KIND_ARC, tag_q, len_q, {24'd0, b / 8'd40}, ERR_NONE));
            add_step_rec(rec(KIND_ARC, tag_q, len_q, {24'd0, b % 8'd40}, ERR_NONE));
          end else begin
            add_step_rec(rec(KIND_ARC, tag_q, len_q, {24'd0, b}, ERR_NONE));
          end
        end else begin
          add_step_rec(rec(KIND_CONTENT, tag_q, len_q, {24'd0, b}, ERR_NONE));
        end
        first_q = 1'b0;
        body_left = body_left - 1;
        if (body_left == 0) begin
          if (scalar_tag(tag_q))
            add_step_rec(rec(KIND_SCALAR, tag_q, len_q, val_q, ERR_NONE));
          ph = PH_TAG;
        end
      end
      default: begin
        if (last_byte) raise_error(b, ERR_TRUNC, last_byte);
        else if (!known_tag(b)) raise_error(b, ERR_TAG, last_byte);
        else begin
          tag_q = b;
          len_q = '0;
          len_left = '0;
          ph = PH_LEN;
        end
      end
    endcase
    if (last_byte && ph != PH_TAG) raise_error(tag_q, ERR_TRUNC, last_byte);
    if (last_byte) drain_q = 1'b0;
    if (step_n > 0) step_recs[step_n - 1].run_last = 1'b1;
  endtask

  // directed rows: byte, end flag, optional pinned first result
  task automatic add_row(input logic [7:0] b, input bit e);
    btlv_in_t it;
    it.data_byte = b;
    it.buffer_end = e;
    stream_mem[stream_len] = it;
    pinned_use[stream_len] = 1'b0;
    pinned_rec[stream_len] = '0;
    stream_len = stream_len + 1;
  endtask

  task automatic add_pinned(input logic [7:0] b, input bit e, input btlv_out_t r);
    add_row(b, e);
    pinned_use[stream_len - 1] = 1'b1;
    pinned_rec[stream_len - 1] = r;
  endtask

  task automatic add_bytes(input logic [7:0] b, input bit e);
    add_row(b, e);
  endtask

  // random well-formed element, sometimes cut short
  task automatic add_element(input bit last_elem);
    logic [7:0] tags[6];
    logic [7:0] t;
    int n;
    int form;
    int cut;
    tags = '{TAG_INT, TAG_OCT, TAG_NULL, TAG_OID, TAG_APP2, TAG_APP3};
    t = tags[$urandom_range(0, 5)];
    n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
    form = $urandom_range(0, 3);
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n + 2) : 0;
    add_bytes(t, 1'b0);
    if (form == 0 && n == 0) add_bytes(8'h80, 1'b0);
    else if (form == 1) begin
      add_bytes(8'h82, 1'b0);
      add_bytes(8'h00, 1'b0);
      add_bytes(n[7:0], 1'b0);
    end else if (form == 2) begin
      add_bytes(8'h81, 1'b0);
      add_bytes(n[7:0], 1'b0);
    end else add_bytes(n[7:0], 1'b0);
    for (int i = 0; i < n; i++) begin
      if (cut != 0 && i + 1 == cut) begin
        add_bytes(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
      add_bytes(8'($urandom_range(0, 255)), 1'b0);
    end
    if (last_elem) begin
      stream_mem[stream_len - 1].buffer_end = 1'b1;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout with %0d results still due", due_wr - due_rd);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result check at the rising edge
  always @(posedge clk) begin
    btlv_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_records <= n_records + 1;
      if (due_rd == due_wr) begin
        errors = errors + 1;
        if (mismatches < 10) $display("unexpected result %p", out_item);
        mismatches = mismatches + 1;
      end else begin
        want = due_mem[due_rd];
        due_rd = due_rd + 1;
        if (want !== out_item) begin
          errors = errors + 1;
          if (mismatches < 10) $display("mismatch: expected %p got %p", want, out_item);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // receiver stall
  initial begin
    int wait_n;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
        hold_long = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (stim_done && due_rd == due_wr) wait_n = 0;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff (out_valid || due_rd == due_wr));
    end
  end

  initial begin
    int gap;
    int idx;
    btlv_in_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    errors = 0;
    mismatches = 0;
    n_bytes = 0;
    n_records = 0;
    cycle_cnt = 0;
    hold_long = 1'b0;
    stim_done = 1'b0;
    due_wr = 0;
    due_rd = 0;
    step_n = 0;
    stream_len = 0;
    stream_rd = 0;
    ph = PH_TAG;
    tag_q = '0;
    len_q = '0;
    len_left = '0;
    body_left = '0;
    val_q = '0;
    first_q = 1'b1;
    drain_q = 1'b0;

    // directed: every tag, length forms, extremes and each error case
    add_pinned(8'h02, 1'b1, rec(KIND_ERROR, 8'h02, 32'd0, 32'd0, ERR_TRUNC));
    add_pinned(8'hff, 1'b0, rec(KIND_ERROR, 8'hff, 32'd0, 32'd0, ERR_TAG));
    add_bytes(8'h00, 1'b0);
    add_bytes(8'h55, 1'b1);
    add_bytes(TAG_INT, 1'b0);
    add_bytes(8'h84, 1'b0);
    add_bytes(8'h00, 1'b0); add_bytes(8'h00, 1'b0); add_bytes(8'h00, 1'b0);
    add_bytes(8'h04, 1'b0);
    add_bytes(8'hff, 1'b0); add_bytes(8'hff, 1'b0); add_bytes(8'hff, 1'b0);
    add_bytes(8'hff, 1'b0);
    add_bytes(TAG_NULL, 1'b0);
    add_pinned(8'h80, 1'b0, rec(KIND_HEADER, TAG_NULL, 32'd0, 32'd0, ERR_NONE));
    add_bytes(TAG_OID, 1'b0); add_bytes(8'h02, 1'b0);
    add_bytes(8'h2b, 1'b0); add_bytes(8'h06, 1'b0);
    add_bytes(TAG_APP2, 1'b0); add_bytes(8'h00, 1'b0);
    add_bytes(TAG_OCT, 1'b0);
    add_pinned(8'h85, 1'b1, rec(KIND_ERROR, TAG_OCT, 32'd0, 32'd0, ERR_LEN));
    add_bytes(TAG_APP3, 1'b0); add_bytes(8'h7f, 1'b1);

    @(negedge clk); @(negedge clk); @(negedge clk);
    rst_n = 1'b1;

    for (int phase_i = 0; phase_i < 2; phase_i++) begin
      while (stream_rd < stream_len) begin
        idx = stream_rd;
        it = stream_mem[stream_rd];
        stream_rd = stream_rd + 1;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (n_bytes == 60) hold_long = 1'b1;
        if (n_bytes == 90 || gap > 0) begin
          in_valid <= 1'b0;
          if (n_bytes == 90) begin
            wait (due_rd == due_wr);
            @(negedge clk);
          end
          repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk iff !in_stall);
        decode_byte(it);
        if (pinned_use[idx] && step_n > 0 &&
            (pinned_rec[idx].record_kind !== step_recs[0].record_kind ||
             pinned_rec[idx].error_code !== step_recs[0].error_code ||
             pinned_rec[idx].element_tag !== step_recs[0].element_tag)) begin
          errors = errors + 1;
          if (mismatches < 10)
            $display("directed row %0d: expected %p got %p", idx, pinned_rec[idx],
                     step_recs[0]);
          mismatches = mismatches + 1;
        end
        for (int i = 0; i < step_n; i++) begin
          due_mem[due_wr] = step_recs[i];
          due_wr = due_wr + 1;
        end
        n_bytes = n_bytes + 1;
        @(negedge clk);
      end
      if (phase_i == 0) begin
        while (stream_len - stream_rd < 90) begin
          int r;
          r = $urandom_range(0, 9);
          if (r == 0) add_bytes(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          else if (r == 1) begin
            add_bytes(TAG_OCT, 1'b0);
            add_bytes(8'h80 | 8'($urandom_range(5, 127)), 1'b0);
          end else add_element(r == 2);
        end
        add_bytes(8'h00, 1'b1);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
    wait (due_rd == due_wr);
    repeat (20) @(posedge clk);
    $display("%0d input bytes, %0d results, directed then random TLV streams", n_bytes,
             n_records);
    $display("covered all tags, long/short lengths, drain, tag/length/truncation errors");
    if (errors == 0 && due_rd == due_wr) begin
      $display("CHECK OK");
    end else begin
      $display("mismatches: %0d", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
